/* hdl/ssdd_pkg.sv */
// Package for the seven-segment digit decoder: item and result types,
// display mode codes, register indexes and the segment lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssdd_pkg;

    // widths and limits
    localparam int WORD_W       = 32;
    localparam int BITS_W       = 6;
    localparam int CNT_W        = 4;
    localparam int SEG_W        = 7;
    localparam int MAX_BITS_DEF = 32;
    localparam int QUEUE_DEPTH  = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT    = 2'd1;

    // reset values of the registers
    localparam logic [1:0]        DISPLAY_MODE_RST = 2'd0;
    localparam logic [BITS_W-1:0] BIT_COUNT_RST    = 6'd8;

    // display modes as classified by the front
    typedef enum logic [1:0] {
        MODE_HEX = 2'd0,
        MODE_RAW = 2'd1,
        MODE_DEC = 2'd2
    } mode_t;

    // raw register codes of display_mode
    localparam logic [1:0] DM_HEX = 2'd0;
    localparam logic [1:0] DM_RAW = 2'd1;
    localparam logic [1:0] DM_DEC = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] valid_mask;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0] digit_position;
        logic [SEG_W-1:0] segments;
        logic [SEG_W-1:0] segment_valid;
        logic             last_digit;
    } result_t;

    // one classified item waiting for the back end
    typedef struct packed {
        logic [WORD_W-1:0] val;
        logic [WORD_W-1:0] vld;
        mode_t             mode;
        logic [CNT_W-1:0]  cnt;
        logic              all_known;
    } job_t;

    // segment pattern of one hex or decimal digit
    function automatic logic [SEG_W-1:0] seg_lookup(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'h0:    s = 7'h77;
            4'h1:    s = 7'h24;
            4'h2:    s = 7'h5D;
            4'h3:    s = 7'h6D;
            4'h4:    s = 7'h2E;
            4'h5:    s = 7'h6B;
            4'h6:    s = 7'h7B;
            4'h7:    s = 7'h25;
            4'h8:    s = 7'h7F;
            4'h9:    s = 7'h2F;
            4'hA:    s = 7'h3F;
            4'hB:    s = 7'h7A;
            4'hC:    s = 7'h53;
            4'hD:    s = 7'h7C;
            4'hE:    s = 7'h5B;
            4'hF:    s = 7'h1B;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* hdl/ssdd_front.sv */
// Front end of the seven-segment digit decoder: configuration registers,
// masking of the input word and digit count per mode.
// Depends on ssdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssdd_front
    import ssdd_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire item_t                 item,
    output job_t                       job
);

    logic [1:0]        display_mode_reg;
    logic [BITS_W-1:0] bit_count_reg;
    logic [BITS_W-1:0] nb;
    logic [WORD_W-1:0] used;
    logic [CNT_W-1:0]  cnt_hex;
    logic [CNT_W-1:0]  cnt_raw;
    logic [CNT_W-1:0]  cnt_dec;
    logic [WORD_W-1:0] vld_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_mode_reg <= DISPLAY_MODE_RST;
            bit_count_reg    <= BIT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DISPLAY_MODE: display_mode_reg <= cfg_data[1:0];
                CFG_BIT_COUNT:    bit_count_reg    <= cfg_data[BITS_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective width, clamped to 1..MAX_BITS
    always_comb
    begin
        if (bit_count_reg == '0)
            nb = BITS_W'(1);
        else if (bit_count_reg > BITS_W'(MAX_BITS))
            nb = BITS_W'(MAX_BITS);
        else
            nb = bit_count_reg;
    end

    assign used     = {WORD_W{1'b1}} >> (BITS_W'(WORD_W) - nb);
    assign vld_full = item.valid_mask | ~used;

    // digit counts: ceil(n/4), ceil(n/7), decimal digits of 2^n - 1
    assign cnt_hex = CNT_W'((nb + BITS_W'(3)) >> 2);

    always_comb
    begin
        if (nb <= BITS_W'(7))       cnt_raw = 4'd1;
        else if (nb <= BITS_W'(14)) cnt_raw = 4'd2;
        else if (nb <= BITS_W'(21)) cnt_raw = 4'd3;
        else if (nb <= BITS_W'(28)) cnt_raw = 4'd4;
        else                        cnt_raw = 4'd5;
    end

    always_comb
    begin
        if (nb <= BITS_W'(3))       cnt_dec = 4'd1;
        else if (nb <= BITS_W'(6))  cnt_dec = 4'd2;
        else if (nb <= BITS_W'(9))  cnt_dec = 4'd3;
        else if (nb <= BITS_W'(13)) cnt_dec = 4'd4;
        else if (nb <= BITS_W'(16)) cnt_dec = 4'd5;
        else if (nb <= BITS_W'(19)) cnt_dec = 4'd6;
        else if (nb <= BITS_W'(23)) cnt_dec = 4'd7;
        else if (nb <= BITS_W'(26)) cnt_dec = 4'd8;
        else if (nb <= BITS_W'(29)) cnt_dec = 4'd9;
        else                        cnt_dec = 4'd10;
    end

    // classify the item for the back end
    always_comb
    begin
        job.val       = item.value & used;
        job.vld       = vld_full;
        job.all_known = &vld_full;
        case (display_mode_reg)
            DM_RAW:
            begin
                job.mode = MODE_RAW;
                job.cnt  = cnt_raw;
            end
            DM_DEC:
            begin
                job.mode = MODE_DEC;
                job.cnt  = cnt_dec;
            end
            default:
            begin
                job.mode = MODE_HEX;
                job.cnt  = cnt_hex;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/ssdd_queue.sv */
// Short queue of classified items between the front and back ends
// of the seven-segment digit decoder.
// Depends on ssdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssdd_queue
    import ssdd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    job_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W_Q-1:0] fill_reg;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == CNT_W_Q'(DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hdl/ssdd_back.sv */
// Back end of the seven-segment digit decoder: walks one item digit by
// digit and drives the registered result, one digit per cycle.
// Depends on ssdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssdd_back
    import ssdd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire job_t head,
    input  wire logic empty,
    output logic      pop,
    output logic      strobe,
    output result_t   result
);

    // reciprocal of ten for a 32-bit dividend, taken with a shift of 35
    localparam logic [WORD_W-1:0] RECIP10 = 32'hCCCCCCCD;
    localparam int                RSHIFT  = 35;
    localparam int                Q_W     = 2 * WORD_W - RSHIFT;

    logic              active_reg, active_next;
    logic [WORD_W-1:0] val_reg, val_next;
    logic [WORD_W-1:0] vld_reg, vld_next;
    mode_t             mode_reg, mode_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              known_reg, known_next;
    logic              strobe_reg;
    result_t           result_reg;

    logic [2*WORD_W-1:0] prod;
    logic [Q_W-1:0]      quot;
    logic [WORD_W-1:0]   quot10;
    logic [3:0]          rem;
    logic                last_now;
    logic [SEG_W-1:0]    seg_v;
    logic [SEG_W-1:0]    seg_k;
    logic [WORD_W-1:0]   val_step;
    logic [WORD_W-1:0]   vld_step;

    // divide by ten through the reciprocal
    assign prod   = {{WORD_W{1'b0}}, val_reg} * {{WORD_W{1'b0}}, RECIP10};
    assign quot   = prod[2*WORD_W-1:RSHIFT];
    assign quot10 = ({{(WORD_W-Q_W){1'b0}}, quot} << 3)
                  + ({{(WORD_W-Q_W){1'b0}}, quot} << 1);
    assign rem    = 4'(val_reg - quot10);

    assign last_now = active_reg && (pos_reg == cnt_reg - 1'b1);
    assign pop      = (!active_reg || last_now) && !empty;

    // digit pattern and advance of the working word
    always_comb
    begin
        case (mode_reg)
            MODE_RAW:
            begin
                seg_v    = val_reg[SEG_W-1:0];
                seg_k    = vld_reg[SEG_W-1:0];
                val_step = val_reg >> 7;
                vld_step = {7'h7F, vld_reg[WORD_W-1:7]};
            end
            MODE_DEC:
            begin
                seg_v    = known_reg ? seg_lookup(rem) : '0;
                seg_k    = known_reg ? {SEG_W{1'b1}} : '0;
                val_step = known_reg ? {{(WORD_W-Q_W){1'b0}}, quot} : val_reg;
                vld_step = vld_reg;
            end
            default:
            begin
                seg_v    = (&vld_reg[3:0]) ? seg_lookup(val_reg[3:0]) : '0;
                seg_k    = (&vld_reg[3:0]) ? {SEG_W{1'b1}} : '0;
                val_step = val_reg >> 4;
                vld_step = {4'hF, vld_reg[WORD_W-1:4]};
            end
        endcase
    end

    // next state of the digit walker
    always_comb
    begin
        active_next = active_reg;
        val_next    = val_step;
        vld_next    = vld_step;
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg + 1'b1;
        known_next  = known_reg;
        if (pop)
        begin
            active_next = 1'b1;
            val_next    = head.val;
            vld_next    = head.vld;
            mode_next   = head.mode;
            cnt_next    = head.cnt;
            pos_next    = '0;
            known_next  = head.all_known;
        end
        else if (last_now || !active_reg)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= active_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        vld_reg   <= vld_next;
        mode_reg  <= mode_next;
        cnt_reg   <= cnt_next;
        pos_reg   <= pos_next;
        known_reg <= known_next;
        result_reg.digit_position <= pos_reg;
        result_reg.segments       <= seg_v;
        result_reg.segment_valid  <= seg_k;
        result_reg.last_digit     <= last_now;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* hdl/seven_segment_digit_decoder.sv */
// Top level of the seven-segment digit decoder.
// Depends on ssdd_pkg, ssdd_front, ssdd_queue and ssdd_back.
//
// An item (value and known-bit mask) is taken at a clock edge with start
// high and busy low, and turns into one result per display digit, least
// significant first, the last one marked by last_digit. Digits leave one
// per cycle on result, each marked by strobe for exactly one cycle; the
// receiver cannot hold them off, so it must take every strobed cycle. An
// item yields ceil(n/4) digits in hexadecimal mode, ceil(n/7) in raw mode
// and the decimal digit count of 2^n - 1 (up to 10) in decimal mode, n
// being the effective bit count; the front end sets this count, and
// successive items run with no gap between them. When the back end is free,
// an accepted item passes the queue slot, the walker and the result register.
// A two-entry queue sits between front and back; busy is high while it is
// full. Configuration writes belong to idle periods only.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_digit_decoder
    import ssdd_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire item_t                 item,
    output logic                       strobe,
    output result_t                    result
);

    logic accept;
    job_t front_job;
    job_t head_job;
    logic q_empty;
    logic q_full;
    logic q_pop;

    assign busy   = q_full;
    assign accept = start && !q_full;

    // front: registers and classification
    ssdd_front #(
        .MAX_BITS (MAX_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .job       (front_job)
    );

    // queue between the two ends
    ssdd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_job (front_job),
        .pop      (q_pop),
        .head     (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: digit walker and result register
    ssdd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head_job),
        .empty  (q_empty),
        .pop    (q_pop),
        .strobe (strobe),
        .result (result)
    );

endmodule

`default_nettype wire
